/* hw/rtl/mu8_pkg.sv */
// ----------------------------------------------------------------------------
// mu8_pkg
// Shared types and constants for the modified UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mu8_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int COUNT_W = 16;
    localparam int PEND_W  = 2;

    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

    // one input beat held in the input register
    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              last_byte;
    } mu8_beat_t;

    // one result beat
    typedef struct packed {
        logic               unit_valid;
        logic [UNIT_W-1:0]  code_unit;
        logic               string_done;
        logic               status;
        logic [COUNT_W-1:0] unit_count;
    } mu8_result_t;

endpackage

`default_nettype wire

/* hw/rtl/mu8_in_stage.sv */
// ----------------------------------------------------------------------------
// mu8_in_stage
// Input register: captures one byte beat and holds it until the decoder takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mu8_in_stage
    import mu8_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] byte_in,
    input  wire logic              last_byte,
    input  wire logic              take,
    output logic                   beat_valid,
    output mu8_beat_t              beat
);

    logic      valid_reg;
    logic      valid_next;
    mu8_beat_t beat_reg;
    logic      load;

    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg.byte_in   <= byte_in;
            beat_reg.last_byte <= last_byte;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

`default_nettype wire

/* hw/rtl/mu8_decode.sv */
// ----------------------------------------------------------------------------
// mu8_decode
// Per-string decode state and the next-state / result logic for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mu8_decode
    import mu8_pkg::*;
#(
    parameter int MAX_STRING_BYTES = 65535
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire mu8_beat_t beat,
    input  wire logic      stop_at_zero,
    output mu8_result_t    result
);

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_STRING_BYTES);

    logic [PEND_W-1:0]  pend_reg,    pend_next;
    logic [UNIT_W-1:0]  partial_reg, partial_next;
    logic               err_reg,     err_next;
    logic               stop_reg,    stop_next;
    logic [COUNT_W-1:0] count_reg,   count_next;

    logic              emit;
    logic [UNIT_W-1:0] unit;
    logic [BYTE_W-1:0] b;

    always_comb
    begin
        b            = beat.byte_in;
        pend_next    = pend_reg;
        partial_next = partial_reg;
        err_next     = err_reg;
        stop_next    = stop_reg;
        count_next   = count_reg;
        emit         = 1'b0;
        unit         = '0;

        if (!err_reg && !stop_reg)
        begin
            if (pend_reg != PEND_NONE)
            begin
                partial_next = {partial_reg[UNIT_W-7:0], b[5:0]};
                pend_next    = pend_reg - PEND_ONE;
                if (pend_reg == PEND_ONE)
                begin
                    emit = 1'b1;
                    unit = partial_next;
                end
            end
            else if (b != '0 && (b & ~ASCII_MASK) == '0)
            begin
                emit = 1'b1;
                unit = {{(UNIT_W-BYTE_W){1'b0}}, b};
            end
            else if ((b & LEAD2_MASK) == LEAD2_CODE)
            begin
                partial_next = {{(UNIT_W-BYTE_W){1'b0}}, b & LEAD2_BITS};
                pend_next    = PEND_ONE;
            end
            else if ((b & LEAD3_MASK) == LEAD3_CODE)
            begin
                partial_next = {{(UNIT_W-BYTE_W){1'b0}}, b & LEAD3_BITS};
                pend_next    = PEND_TWO;
            end
            else if (b == '0 && stop_at_zero)
            begin
                stop_next = 1'b1;
            end
            else
            begin
                err_next = 1'b1;
            end
        end

        if (emit && count_reg < COUNT_MAX)
        begin
            count_next = count_reg + COUNT_W'(1);
        end

        result.unit_valid  = emit;
        result.code_unit   = unit;
        result.string_done = beat.last_byte;
        result.status      = 1'b0;
        result.unit_count  = '0;

        if (beat.last_byte)
        begin
            // a sequence cut off by the end of the string is an error
            if (!err_next && !stop_next && pend_next != PEND_NONE)
            begin
                err_next = 1'b1;
            end
            result.status     = err_next;
            result.unit_count = err_next ? '0 : count_next;
            pend_next    = PEND_NONE;
            partial_next = '0;
            err_next     = 1'b0;
            stop_next    = 1'b0;
            count_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= PEND_NONE;
            partial_reg <= '0;
            err_reg     <= 1'b0;
            stop_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else if (step)
        begin
            pend_reg    <= pend_next;
            partial_reg <= partial_next;
            err_reg     <= err_next;
            stop_reg    <= stop_next;
            count_reg   <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mu8_out_stage.sv */
// ----------------------------------------------------------------------------
// mu8_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mu8_out_stage
    import mu8_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load_valid,
    input  wire mu8_result_t load_data,
    output logic             load_ready,
    output logic             out_valid,
    input  wire logic        out_stall,
    output mu8_result_t      out_data
);

    logic        valid_reg;
    mu8_result_t data_reg;
    logic        load;

    assign load_ready = !valid_reg || !out_stall;
    assign load       = load_valid && load_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ready)
        begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* hw/rtl/modified_utf8_to_utf16_decoder.sv */
// ----------------------------------------------------------------------------
// modified_utf8_to_utf16_decoder
// Decodes a modified UTF-8 byte stream into 16-bit UTF-16 code units.
// ----------------------------------------------------------------------------
// Input channel: one byte per beat (byte_in, last_byte), in_valid / in_stall.
// Output channel: one result beat per input beat, out_valid / out_stall.
// A result carries unit_valid/code_unit when a unit completes; the result for
// the last byte also has string_done, status and unit_count (count is zero
// when status flags an invalid string, and emitted units must be dropped).
// cfg_wr_en / cfg_wr_data write stop_at_zero; write only while idle.
// An input beat passes through the input register, then the decode logic into
// the result register, before it appears as a result beat.
// Throughput: one byte per cycle while the receiver does not stall.
// Reset clears the decode state, stop_at_zero and the valid flags of both pipeline registers.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall then rises until the result beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module modified_utf8_to_utf16_decoder
    import mu8_pkg::*;
#(
    parameter int MAX_STRING_BYTES = 65535
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [BYTE_W-1:0]  byte_in,
    input  wire logic               last_byte,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    unit_valid,
    output logic [UNIT_W-1:0]       code_unit,
    output logic                    string_done,
    output logic                    status,
    output logic [COUNT_W-1:0]      unit_count
);

    logic        stop_at_zero_reg;
    logic        beat_valid;
    mu8_beat_t   beat;
    logic        load_ready;
    logic        step;
    mu8_result_t result;
    mu8_result_t out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_at_zero_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            stop_at_zero_reg <= cfg_wr_data;
        end
    end

    assign step = beat_valid && load_ready;

    mu8_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_in    (byte_in),
        .last_byte  (last_byte),
        .take       (step),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    mu8_decode #(
        .MAX_STRING_BYTES (MAX_STRING_BYTES)
    ) u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .beat         (beat),
        .stop_at_zero (stop_at_zero_reg),
        .result       (result)
    );

    mu8_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (beat_valid),
        .load_data  (result),
        .load_ready (load_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    assign unit_valid  = out_data.unit_valid;
    assign code_unit   = out_data.code_unit;
    assign string_done = out_data.string_done;
    assign status      = out_data.status;
    assign unit_count  = out_data.unit_count;

endmodule

`default_nettype wire

/* test/modified_utf8_to_utf16_decoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modified_utf8_to_utf16_decoder_tb
// Self-checking bench for the modified UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
// Bytes are sent as strings over the valid/stall input channel. A behavioral
// decoder in the bench predicts one result per accepted byte, and every
// result beat is checked field by field against the oldest prediction.
// Directed strings hit the byte classes, error paths and the stop-at-zero
// mode. Random strings, mostly well formed, run under three idle/stall mixes
// with stop_at_zero toggled between phases.
// ----------------------------------------------------------------------------

module modified_utf8_to_utf16_decoder_tb;

    import mu8_pkg::*;

    localparam int MAX_STRING_BYTES = 65535;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int PHASE_BYTES      = 650;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic               cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    logic [BYTE_W-1:0]  byte_in;
    logic               last_byte;
    logic               out_valid;
    logic               out_stall;
    logic               unit_valid;
    logic [UNIT_W-1:0]  code_unit;
    logic               string_done;
    logic               status;
    logic [COUNT_W-1:0] unit_count;

    // bench copy of the decoder state and register
    logic               stop_zero_cfg;
    logic [PEND_W-1:0]  dec_pend;
    logic [UNIT_W-1:0]  dec_partial;
    logic               dec_err;
    logic               dec_stopped;
    logic [COUNT_W-1:0] dec_units;

    mu8_result_t        predicted_decodes[$];
    logic [BYTE_W-1:0]  str_bytes[$];

    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 bytes_sent;
    int                 cycle_count;
    logic               mismatch_seen;

    modified_utf8_to_utf16_decoder #(
        .MAX_STRING_BYTES (MAX_STRING_BYTES)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_in     (byte_in),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .unit_valid  (unit_valid),
        .code_unit   (code_unit),
        .string_done (string_done),
        .status      (status),
        .unit_count  (unit_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("modified_utf8_to_utf16_decoder regression: fail");
        $finish;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        mu8_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_decodes.size() == 0)
            begin
                $error("result beat with no prediction pending");
                mismatch_seen = 1'b1;
            end
            else
            begin
                exp_res = predicted_decodes.pop_front();
                if (unit_valid !== exp_res.unit_valid)
                begin
                    $error("unit_valid: expected %0d, got %0d", exp_res.unit_valid, unit_valid);
                    mismatch_seen = 1'b1;
                end
                if (code_unit !== exp_res.code_unit)
                begin
                    $error("code_unit: expected %0h, got %0h", exp_res.code_unit, code_unit);
                    mismatch_seen = 1'b1;
                end
                if (string_done !== exp_res.string_done)
                begin
                    $error("string_done: expected %0d, got %0d",
                           exp_res.string_done, string_done);
                    mismatch_seen = 1'b1;
                end
                if (status !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, status);
                    mismatch_seen = 1'b1;
                end
                if (unit_count !== exp_res.unit_count)
                begin
                    $error("unit_count: expected %0d, got %0d",
                           exp_res.unit_count, unit_count);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Decode predictor: one result per accepted byte
    // ------------------------------------------------------------------
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic lst);
        mu8_result_t res;
        begin
            res = '0;
            if (!dec_err && !dec_stopped)
            begin
                if (dec_pend != PEND_NONE)
                begin
                    // continuation bits are taken unchecked
                    dec_partial = {dec_partial[UNIT_W-7:0], b[5:0]};
                    dec_pend    = dec_pend - 1'b1;
                    if (dec_pend == PEND_NONE)
                    begin
                        res.unit_valid = 1'b1;
                        res.code_unit  = dec_partial;
                    end
                end
                else if (b != '0 && b <= ASCII_MASK)
                begin
                    res.unit_valid = 1'b1;
                    res.code_unit  = {8'h00, b};
                end
                else if ((b & LEAD2_MASK) == LEAD2_CODE)
                begin
                    dec_partial = {8'h00, b & LEAD2_BITS};
                    dec_pend    = PEND_ONE;
                end
                else if ((b & LEAD3_MASK) == LEAD3_CODE)
                begin
                    dec_partial = {8'h00, b & LEAD3_BITS};
                    dec_pend    = PEND_TWO;
                end
                else if (b == '0 && stop_zero_cfg)
                    dec_stopped = 1'b1;
                else
                    dec_err = 1'b1;
            end

            if (res.unit_valid && dec_units < MAX_STRING_BYTES)
                dec_units = dec_units + 1'b1;

            res.string_done = lst;
            if (lst)
            begin
                // cut-off sequence counts as invalid
                if (!dec_err && !dec_stopped && dec_pend != PEND_NONE)
                    dec_err = 1'b1;
                res.status     = dec_err;
                res.unit_count = dec_err ? '0 : dec_units;
                dec_pend    = PEND_NONE;
                dec_partial = '0;
                dec_err     = 1'b0;
                dec_stopped = 1'b0;
                dec_units   = '0;
            end
            predicted_decodes.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------
    // Driving helpers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
        begin
            @(negedge clk);
            // each cycle idles with the set probability
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid  <= 1'b1;
            byte_in   <= b;
            last_byte <= lst;
            do
                @(posedge clk);
            while (in_stall);
            decode_byte(b, lst);
            bytes_sent++;
        end
    endtask

    // sends str_bytes as one string, last flag on the final byte
    task automatic send_string();
        int i;
        begin
            for (i = 0; i < str_bytes.size(); i++)
                send_byte(str_bytes[i], i == str_bytes.size() - 1);
            str_bytes.delete();
        end
    endtask

    task automatic wait_drained();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (predicted_decodes.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic write_stop_at_zero(input logic val);
        begin
            wait_drained();
            @(negedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= val;
            @(negedge clk);
            cfg_wr_en   <= 1'b0;
            stop_zero_cfg = val;
        end
    endtask

    function automatic logic [BYTE_W-1:0] rand_cont();
        if ($urandom_range(99) < 20)
            return BYTE_W'($urandom_range(255));
        return {2'b10, 6'($urandom_range(63))};
    endfunction

    // mostly well-formed text, with stray bytes and cut-off tails mixed in
    task automatic build_random_string();
        int n_chars;
        int i;
        int kind;
        begin
            n_chars = $urandom_range(1, 10);
            for (i = 0; i < n_chars; i++)
            begin
                kind = $urandom_range(99);
                if (kind < 40)
                    str_bytes.push_back(BYTE_W'($urandom_range(1, 127)));
                else if (kind < 65)
                begin
                    str_bytes.push_back({3'b110, 5'($urandom_range(31))});
                    str_bytes.push_back(rand_cont());
                end
                else if (kind < 90)
                begin
                    str_bytes.push_back({4'b1110, 4'($urandom_range(15))});
                    str_bytes.push_back(rand_cont());
                    str_bytes.push_back(rand_cont());
                end
                else if (kind < 93)
                    str_bytes.push_back({2'b10, 6'($urandom_range(63))});
                else if (kind < 96)
                    str_bytes.push_back({4'b1111, 4'($urandom_range(15))});
                else
                    str_bytes.push_back(8'h00);
            end
            kind = $urandom_range(99);
            if (kind < 5)
                str_bytes.push_back({3'b110, 5'($urandom_range(31))});
            else if (kind < 10)
            begin
                str_bytes.push_back({4'b1110, 4'($urandom_range(15))});
                if ($urandom_range(1))
                    str_bytes.push_back(rand_cont());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_single_byte_units();
        begin
            str_bytes = '{8'h01, 8'h7F};
            send_string();
        end
    endtask

    task automatic test_two_byte_units();
        begin
            str_bytes = '{8'hC0, 8'h80, 8'hDF, 8'hBF};
            send_string();
        end
    endtask

    task automatic test_three_byte_units();
        begin
            str_bytes = '{8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF};
            send_string();
        end
    endtask

    task automatic test_invalid_leads();
        begin
            // error is sticky: the trailing 'A' yields no unit
            str_bytes = '{8'h80, 8'h41};
            send_string();
            str_bytes = '{8'hF0};
            send_string();
            str_bytes = '{8'hFF};
            send_string();
            str_bytes = '{8'h00};
            send_string();
        end
    endtask

    task automatic test_truncated_sequences();
        begin
            str_bytes = '{8'h41, 8'hC3};
            send_string();
            str_bytes = '{8'hE1, 8'h80};
            send_string();
        end
    endtask

    task automatic test_zero_continuation();
        begin
            str_bytes = '{8'hC0, 8'h00};
            send_string();
        end
    endtask

    task automatic test_stop_at_zero();
        begin
            write_stop_at_zero(1'b1);
            str_bytes = '{8'h41, 8'h00, 8'h42};
            send_string();
            str_bytes = '{8'h00};
            send_string();
            write_stop_at_zero(1'b0);
        end
    endtask

    task automatic test_random_strings(input int send_pct, input int recv_pct);
        int start_bytes;
        logic paused;
        begin
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
            start_bytes   = bytes_sent;
            paused        = 1'b0;
            while (bytes_sent - start_bytes < PHASE_BYTES)
            begin
                build_random_string();
                send_string();
                // hold the sender once until the output side is empty
                if (!paused && bytes_sent - start_bytes > PHASE_BYTES / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        in_valid      = 1'b0;
        byte_in       = '0;
        last_byte     = 1'b0;
        out_stall     = 1'b0;
        stop_zero_cfg = 1'b0;
        dec_pend      = PEND_NONE;
        dec_partial   = '0;
        dec_err       = 1'b0;
        dec_stopped   = 1'b0;
        dec_units     = '0;
        send_idle_pct = 16;
        recv_idle_pct = 55;
        bytes_sent    = 0;
        cycle_count   = 0;
        mismatch_seen = 1'b0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_single_byte_units();
        test_two_byte_units();
        test_three_byte_units();
        test_invalid_leads();
        test_truncated_sequences();
        test_zero_continuation();
        test_stop_at_zero();

        test_random_strings(16, 55);
        write_stop_at_zero(1'b1);
        test_random_strings(55, 16);
        write_stop_at_zero(1'b0);
        test_random_strings(0, 0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (!mismatch_seen && predicted_decodes.size() == 0)
            $display("modified_utf8_to_utf16_decoder regression: pass");
        else
            $display("modified_utf8_to_utf16_decoder regression: fail");
        $finish;
    end

endmodule

/* modified_utf8_to_utf16_decoder.f */
hw/rtl/mu8_pkg.sv
hw/rtl/mu8_in_stage.sv
hw/rtl/mu8_decode.sv
hw/rtl/mu8_out_stage.sv
hw/rtl/modified_utf8_to_utf16_decoder.sv
test/modified_utf8_to_utf16_decoder_tb.sv
